FILE: src/tensor_section_address_walker_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the section address walker
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TENSOR_SECTION_ADDRESS_WALKER_CORE_ASSERT_SVH
`define TENSOR_SECTION_ADDRESS_WALKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define TSAW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define TSAW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define TSAW_ASSERT(lbl, prop, msg)
`define TSAW_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: src/tsaw_pkg.sv
// ---------------------------------------------------------------------------
// tsaw_pkg
// Shared types and constants of the section address walker.
// ---------------------------------------------------------------------------
`default_nettype none

package tsaw_pkg;

  // corner coordinates carried by one input beat
  localparam int IN_DIMS  = 4;
  localparam int FIELD_W  = 16;
  localparam int INDEX_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SIZE_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_DIMS = 3'd0,
    REG_ROW_MAJOR   = 3'd1,
    REG_DIM_SIZE_0  = 3'd2,
    REG_DIM_SIZE_1  = 3'd3,
    REG_DIM_SIZE_2  = 3'd4,
    REG_DIM_SIZE_3  = 3'd5
  } tsaw_reg_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } tsaw_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_DONE
  } tsaw_back_state_e;

  typedef struct packed {
    logic last;
    logic no_walk;
  } tsaw_flags_t;

  typedef struct packed {
    logic walk_active;
    logic last;
  } tsaw_front_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tsaw_q_status_t;

endpackage

`default_nettype wire

FILE: src/tsaw_front.sv
// ---------------------------------------------------------------------------
// tsaw_front
// Holds the walk state, classifies each beat, steps the odometer and hands
// the new coordinate, running count and flags to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module tsaw_front
  import tsaw_pkg::*;
#(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 16,
  parameter int CNT_W      = $clog2(MAX_DIMS + 1),
  parameter int IDX_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [CNT_W-1:0]                     n_dims_i,
  input  logic                                 row_major_i,
  input  logic                                 accept_i,
  input  logic                                 kind_i,
  input  logic [IN_DIMS-1:0][FIELD_W-1:0]      low_i,
  input  logic [IN_DIMS-1:0][FIELD_W-1:0]      high_i,
  output logic [MAX_DIMS-1:0][COORD_BITS-1:0]  coords_o,
  output logic [INDEX_W-1:0]                   count_o,
  output tsaw_flags_t                          flags_o,
  output tsaw_front_status_t                   status_o
);

  logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord_q, coord_d;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] low_q, high_q;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] lo_ext, hi_ext;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] next_c, cand_high;
  logic [INDEX_W-1:0]                  count_q, count_d;
  logic                                walk_q;
  logic                                is_start, no_walk, fin;

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_ext
    if (g < IN_DIMS) begin : g_in
      assign lo_ext[g] = COORD_BITS'(low_i[g]);
      assign hi_ext[g] = COORD_BITS'(high_i[g]);
    end else begin : g_zero
      assign lo_ext[g] = '0;
      assign hi_ext[g] = '0;
    end
  end

  assign is_start = (kind_i == KIND_START);
  assign no_walk  = (kind_i == KIND_STEP) && !walk_q;

  // odometer step, fastest position first; carry ripples while dims wrap
  always_comb begin
    logic             carry;
    logic [IDX_W-1:0] d;
    next_c = coord_q;
    carry  = 1'b1;
    d      = '0;
    for (int p = 0; p < MAX_DIMS; p++) begin
      if (p < int'(n_dims_i)) begin
        d = row_major_i ? IDX_W'(int'(n_dims_i) - 1 - p) : IDX_W'(p);
        if (carry) begin
          if (coord_q[d] >= high_q[d]) begin
            next_c[d] = low_q[d];
          end else begin
            next_c[d] = coord_q[d] + 1'b1;
            carry     = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    coord_d   = is_start ? lo_ext : next_c;
    cand_high = is_start ? hi_ext : high_q;
    fin = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (d < int'(n_dims_i) && coord_d[d] < cand_high[d]) fin = 1'b0;
    end
    count_d = is_start ? '0 : count_q + 1'b1;
  end

  assign coords_o         = no_walk ? '0 : coord_d;
  assign count_o          = no_walk ? '0 : count_d;
  assign flags_o.last     = !no_walk && fin;
  assign flags_o.no_walk  = no_walk;
  assign status_o.walk_active = walk_q;
  assign status_o.last        = flags_o.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
      low_q   <= '0;
      high_q  <= '0;
      count_q <= '0;
      walk_q  <= 1'b0;
    end else if (accept_i && !no_walk) begin
      coord_q <= coord_d;
      count_q <= count_d;
      walk_q  <= !fin;
      if (is_start) begin
        low_q  <= lo_ext;
        high_q <= hi_ext;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/tsaw_queue.sv
// ---------------------------------------------------------------------------
// tsaw_queue
// Short flop FIFO between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module tsaw_queue
  import tsaw_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output tsaw_q_status_t   status_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign data_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: src/tsaw_back.sv
// ---------------------------------------------------------------------------
// tsaw_back
// Turns a queued coordinate into the linear tensor index, one dimension
// per cycle (stride multiply, then accumulate), and drives the output beat.
// ---------------------------------------------------------------------------
`default_nettype none

module tsaw_back
  import tsaw_pkg::*;
#(
  parameter int MAX_DIMS   = 4,
  parameter int COORD_BITS = 16,
  parameter int CNT_W      = $clog2(MAX_DIMS + 1),
  parameter int IDX_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [CNT_W-1:0]                     n_dims_i,
  input  logic                                 row_major_i,
  input  logic [MAX_DIMS-1:0][SIZE_W-1:0]      dim_size_i,
  input  logic                                 q_empty_i,
  input  logic [MAX_DIMS-1:0][COORD_BITS-1:0]  q_coords_i,
  input  logic [INDEX_W-1:0]                   q_count_i,
  input  tsaw_flags_t                          q_flags_i,
  output logic                                 pop_o,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [INDEX_W-1:0]                   tensor_index_o,
  output logic [INDEX_W-1:0]                   section_index_o,
  output tsaw_flags_t                          flags_o
);

  tsaw_back_state_e state_q, state_d;

  logic [MAX_DIMS-1:0][COORD_BITS-1:0] coords_q;
  logic [INDEX_W-1:0] count_q, sum_q, prod_q, stride_q;
  logic [INDEX_W-1:0] prod_d, stride_d;
  tsaw_flags_t        flags_q;
  logic [CNT_W-1:0]   pos_q;
  logic [IDX_W-1:0]   dim;
  logic               in_range, slot_free, load_out;

  logic               out_valid_q;
  logic [INDEX_W-1:0] out_tidx_q, out_sidx_q;
  tsaw_flags_t        out_flags_q;

  assign slot_free = !out_valid_q || m_ready_i;
  assign in_range  = (pos_q < n_dims_i);
  assign dim = row_major_i ? IDX_W'(int'(n_dims_i) - 1 - int'(pos_q)) : IDX_W'(pos_q);
  assign prod_d   = in_range ? stride_q * INDEX_W'(coords_q[dim]) : '0;
  assign stride_d = in_range ? stride_q * INDEX_W'(dim_size_i[dim]) : stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          state_d = q_flags_i.no_walk ? BK_DONE : BK_CALC;
        end
      end
      BK_CALC: begin
        // one extra pass drains the last product into the sum
        if (pos_q == n_dims_i) state_d = BK_DONE;
      end
      BK_DONE: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      coords_q <= q_coords_i;
      count_q  <= q_count_i;
      flags_q  <= q_flags_i;
      sum_q    <= '0;
      prod_q   <= '0;
      stride_q <= INDEX_W'(1);
      pos_q    <= '0;
    end else if (state_q == BK_CALC) begin
      sum_q    <= sum_q + prod_q;
      prod_q   <= prod_d;
      stride_q <= stride_d;
      pos_q    <= pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_tidx_q  <= sum_q;
      out_sidx_q  <= count_q;
      out_flags_q <= flags_q;
    end
  end

  assign m_valid_o       = out_valid_q;
  assign tensor_index_o  = out_tidx_q;
  assign section_index_o = out_sidx_q;
  assign flags_o         = out_flags_q;

endmodule

`default_nettype wire

FILE: src/tensor_section_address_walker_core.sv
// ---------------------------------------------------------------------------
// tensor_section_address_walker_core
// Walks a box of an N-dimensional tensor and emits, per element, its linear
// tensor index and its running index within the section.
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_*     | in  | tdata: low_0..3, high_0..3 (16b each); tuser: kind
//  m_*     | out | tdata: tensor_index, section_index; tlast: last; tuser: no_walk
//  cfg_*   | in  | cfg_index_i selects register, cfg_data_i is written
//
//  An element passes through the back end's idle, calc and done states; calc
//  covers one of the n active dims (clamped to 1..MAX_DIMS) per cycle by stride
//  multiply/accumulate, plus a drain pass; a no-walk step skips calc.
//  Reset clears the walk state and loads register defaults; no clearing pass.
//  A QUEUE_DEPTH entry queue and an output register decouple the sides.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tensor_section_address_walker_core_assert.svh"

module tensor_section_address_walker_core
  import tsaw_pkg::*;
#(
  parameter int MAX_DIMS    = 4,
  parameter int COORD_BITS  = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [127:0]          s_tdata_i,   // low_0..low_3, high_0..high_3
  input  logic                  s_tuser_i,   // kind
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [63:0]           m_tdata_o,   // tensor_index, section_index
  output logic                  m_tlast_o,
  output logic                  m_tuser_o,   // no_walk
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CNT_W   = $clog2(MAX_DIMS + 1);
  localparam int FLAGS_W = $bits(tsaw_flags_t);
  localparam int ENTRY_W = MAX_DIMS * COORD_BITS + INDEX_W + FLAGS_W;

  logic [2:0]                     active_dims_q;
  logic                           row_major_q;
  logic [MAX_DIMS-1:0][SIZE_W-1:0] dim_size_q;
  logic [CNT_W-1:0]               n_dims;

  logic                           s_accept;
  logic [IN_DIMS-1:0][FIELD_W-1:0] low, high;

  logic [MAX_DIMS-1:0][COORD_BITS-1:0] f_coords, q_coords;
  logic [INDEX_W-1:0]             f_count, q_count;
  tsaw_flags_t                    f_flags, q_flags, m_flags;
  tsaw_front_status_t             f_status;
  tsaw_q_status_t                 q_status;
  logic [ENTRY_W-1:0]             q_wdata, q_rdata;
  logic                           q_pop;
  logic [INDEX_W-1:0]             tensor_index, section_index;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_dims_q <= 3'd1;
      row_major_q   <= 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) dim_size_q[d] <= SIZE_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        REG_ACTIVE_DIMS: active_dims_q <= cfg_data_i[2:0];
        REG_ROW_MAJOR:   row_major_q   <= cfg_data_i[0];
        REG_DIM_SIZE_0, REG_DIM_SIZE_1, REG_DIM_SIZE_2, REG_DIM_SIZE_3: begin
          for (int d = 0; d < MAX_DIMS; d++) begin
            if (d < IN_DIMS && int'(cfg_index_i) == int'(REG_DIM_SIZE_0) + d)
              dim_size_q[d] <= cfg_data_i;
          end
        end
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (active_dims_q == '0)                    n_dims = CNT_W'(1);
    else if (int'(active_dims_q) > MAX_DIMS)    n_dims = CNT_W'(MAX_DIMS);
    else                                        n_dims = CNT_W'(active_dims_q);
  end

  assign s_tready_o = !q_status.full;
  assign s_accept   = s_tvalid_i && s_tready_o;

  for (genvar g = 0; g < IN_DIMS; g++) begin : g_unpack
    assign low[g]  = s_tdata_i[g*FIELD_W +: FIELD_W];
    assign high[g] = s_tdata_i[(IN_DIMS + g)*FIELD_W +: FIELD_W];
  end

  tsaw_front #(
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_dims_i    (n_dims),
    .row_major_i (row_major_q),
    .accept_i    (s_accept),
    .kind_i      (s_tuser_i),
    .low_i       (low),
    .high_i      (high),
    .coords_o    (f_coords),
    .count_o     (f_count),
    .flags_o     (f_flags),
    .status_o    (f_status)
  );

  assign q_wdata = {f_coords, f_count, f_flags};

  tsaw_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (s_accept),
    .data_i   (q_wdata),
    .pop_i    (q_pop),
    .data_o   (q_rdata),
    .status_o (q_status)
  );

  assign {q_coords, q_count, q_flags} = q_rdata;

  tsaw_back #(
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .n_dims_i        (n_dims),
    .row_major_i     (row_major_q),
    .dim_size_i      (dim_size_q),
    .q_empty_i       (q_status.empty),
    .q_coords_i      (q_coords),
    .q_count_i       (q_count),
    .q_flags_i       (q_flags),
    .pop_o           (q_pop),
    .m_valid_o       (m_tvalid_o),
    .m_ready_i       (m_tready_i),
    .tensor_index_o  (tensor_index),
    .section_index_o (section_index),
    .flags_o         (m_flags)
  );

  assign m_tdata_o = {section_index, tensor_index};
  assign m_tlast_o = m_flags.last;
  assign m_tuser_o = m_flags.no_walk;

  // checks
  `TSAW_ASSERT(a_last_ends_walk, s_accept && f_status.last |=> !f_status.walk_active, "walk still active after last element")
  `TSAW_ASSERT(a_no_walk_zero, m_tvalid_o && m_tuser_o |-> m_tdata_o == '0 && !m_tlast_o, "no-walk beat carries indices")
  `TSAW_ASSERT_NEVER(a_pop_empty, q_pop && q_status.empty, "back end popped an empty queue")
  `TSAW_ASSERT_NEVER(a_queue_state, q_status.full && q_status.empty, "queue both full and empty")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the section address walker. A short table of
// directed beats and register writes runs first; random box walks over
// several register settings follow. Output beats are checked against a row's
// expected beat or an in-bench odometer model. Both streams stall at random.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsaw_pkg::*;

  localparam int DRAIN_CYCLES = 32;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 170;
  localparam int MAX_SHOWN = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef logic [IN_DIMS-1:0][FIELD_W-1:0] coords_t;

  typedef struct packed {
    logic [INDEX_W-1:0] tensor_index;
    logic [INDEX_W-1:0] section_index;
    logic               last;
    logic               no_walk;
  } addr_beat_t;

  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    tsaw_kind_e            kind;
    coords_t               lo;
    coords_t               hi;
    logic                  typed;
    addr_beat_t            want;
  } probe_row_t;

  localparam addr_beat_t IDLE_STEP = '{32'd0, 32'd0, 1'b0, 1'b1};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [127:0]          s_tdata_i = '0;   // low_0..low_3, high_0..high_3
  logic                  s_tuser_i = 1'b0; // kind
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [63:0]           m_tdata_o;        // tensor_index, section_index
  logic                  m_tlast_o;
  logic                  m_tuser_o;        // no_walk
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  tensor_section_address_walker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2ns clk_i = ~clk_i;

  // walker model: registers and walk state, reset values
  logic [2:0]         cfg_dims = 3'd1;
  logic               cfg_row = 1'b1;
  logic [SIZE_W-1:0]  cfg_size [IN_DIMS] = '{default: 16'd1};
  logic [FIELD_W-1:0] pos [IN_DIMS] = '{default: '0};
  logic [FIELD_W-1:0] box_lo [IN_DIMS] = '{default: '0};
  logic [FIELD_W-1:0] box_hi [IN_DIMS] = '{default: '0};
  logic [INDEX_W-1:0] sec_count = '0;
  bit                 walking = 1'b0;

  addr_beat_t pending_addr [$];
  probe_row_t probes [$];
  int         fails = 0;
  int         beats_sent = 0;
  bit         calm = 1'b0;
  bit         item_up = 1'b0;
  bit         reg_up = 1'b0;

  function automatic int used_dims();
    if (cfg_dims == 3'd0) return 1;
    if (int'(cfg_dims) > IN_DIMS) return IN_DIMS;
    return int'(cfg_dims);
  endfunction

  // fastest dimension first
  function automatic int dim_of(int p, int n);
    return cfg_row ? n - 1 - p : p;
  endfunction

  function automatic addr_beat_t walk_address(tsaw_kind_e kind, coords_t lo, coords_t hi);
    addr_beat_t res;
    int n;
    int d;
    bit fin;
    logic [INDEX_W-1:0] stride;
    res = '0;
    n = used_dims();
    if (kind == KIND_START) begin
      for (int k = 0; k < IN_DIMS; k++) begin
        box_lo[k] = lo[k];
        box_hi[k] = hi[k];
        pos[k] = lo[k];
      end
      sec_count = '0;
    end else if (!walking) begin
      res.no_walk = 1'b1;
      return res;
    end else begin
      for (int p = 0; p < n; p++) begin
        d = dim_of(p, n);
        if (pos[d] >= box_hi[d]) begin
          pos[d] = box_lo[d];
        end else begin
          pos[d] = pos[d] + 1'b1;
          break;
        end
      end
      sec_count = sec_count + 1'b1;
    end
    fin = 1'b1;
    for (int k = 0; k < n; k++)
      if (pos[k] < box_hi[k]) fin = 1'b0;
    walking = !fin;
    stride = 32'd1;
    for (int p = 0; p < n; p++) begin
      d = dim_of(p, n);
      res.tensor_index = res.tensor_index + stride * INDEX_W'(pos[d]);
      stride = stride * INDEX_W'(cfg_size[d]);
    end
    res.section_index = sec_count;
    res.last = fin;
    return res;
  endfunction

  function automatic coords_t corner(int c0, int c1, int c2, int c3);
    return {FIELD_W'(c3), FIELD_W'(c2), FIELD_W'(c1), FIELD_W'(c0)};
  endfunction

  function automatic probe_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    probe_row_t row;
    row = '0;
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic probe_row_t item_row(tsaw_kind_e kind, coords_t lo, coords_t hi);
    probe_row_t row;
    row = '0;
    row.kind = kind;
    row.lo = lo;
    row.hi = hi;
    return row;
  endfunction

  function automatic probe_row_t known_row(tsaw_kind_e kind, coords_t lo, coords_t hi,
                                           addr_beat_t want);
    probe_row_t row;
    row = item_row(kind, lo, hi);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return FIELD_W'($urandom_range(0, 7));
    if (r < 35) return FIELD_W'($urandom_range(65530, 65534));
    return FIELD_W'($urandom_range(0, 65534));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 12) return SIZE_W'(1);
    if (r < 20) return '1;
    return SIZE_W'($urandom_range(1, 65535));
  endfunction

  function automatic coords_t any_corner();
    coords_t c;
    for (int k = 0; k < IN_DIMS; k++) c[k] = FIELD_W'($urandom_range(0, 65534));
    return c;
  endfunction

  // small box; now and then a dimension with its corners crossed
  task automatic make_box(output coords_t lo, output coords_t hi);
    int ext;
    for (int k = 0; k < IN_DIMS; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        lo[k] = FIELD_W'($urandom_range(1, 65534));
        hi[k] = FIELD_W'($urandom_range(0, int'(lo[k]) - 1));
      end else begin
        lo[k] = pick_coord();
        ext = $urandom_range(0, 2);
        hi[k] = (int'(lo[k]) > 65534 - ext) ? FIELD_W'(65534) : lo[k] + FIELD_W'(ext);
      end
    end
  endtask

  task automatic push_item(tsaw_kind_e kind, coords_t lo, coords_t hi, bit typed,
                           addr_beat_t want);
    addr_beat_t pred;
    if (reg_up) begin
      cfg_valid_i <= 1'b0;
      reg_up = 1'b0;
    end
    if (!calm && $urandom_range(0, 99) < 32) begin
      if (item_up) s_tvalid_i <= 1'b0;
      item_up = 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 32);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i <= kind;
    s_tdata_i <= {hi, lo};
    item_up = 1'b1;
    do @(posedge clk_i); while (!s_tready_o);
    pred = walk_address(kind, lo, hi);
    pending_addr.push_back(typed ? want : pred);
    beats_sent++;
  endtask

  // only with the walker drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (item_up) begin
      s_tvalid_i <= 1'b0;
      item_up = 1'b0;
    end
    while (pending_addr.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    reg_up = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ACTIVE_DIMS: cfg_dims = val[2:0];
      REG_ROW_MAJOR:   cfg_row = val[0];
      REG_DIM_SIZE_0, REG_DIM_SIZE_1, REG_DIM_SIZE_2, REG_DIM_SIZE_3:
        cfg_size[idx - REG_DIM_SIZE_0] = val;
      default: ;
    endcase
  endtask

  task automatic report_bad(string why, addr_beat_t want, addr_beat_t got);
    fails++;
    if (fails <= MAX_SHOWN)
      $display("%0t: %s: expected ti=%h si=%h last=%b nw=%b, got ti=%h si=%h last=%b nw=%b",
               $realtime, why, want.tensor_index, want.section_index, want.last, want.no_walk,
               got.tensor_index, got.section_index, got.last, got.no_walk);
  endtask

  always @(posedge clk_i) m_tready_i <= calm || ($urandom_range(0, 99) >= 32);

  always @(posedge clk_i) begin : watch_out
    addr_beat_t got;
    addr_beat_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = '{m_tdata_o[31:0], m_tdata_o[63:32], m_tlast_o, m_tuser_o};
      if (pending_addr.size() == 0) begin
        report_bad("unexpected beat", '0, got);
      end else begin
        want = pending_addr.pop_front();
        if (got.tensor_index !== want.tensor_index || got.section_index !== want.section_index
            || got.last !== want.last || got.no_walk !== want.no_walk)
          report_bad("beat mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    coords_t lo;
    coords_t hi;
    logic [2:0] dims;
    logic row;
    logic [SIZE_W-1:0] sz [IN_DIMS];
    int target;
    int r;

    // reset defaults: one dimension, unit size
    probes.push_back(known_row(KIND_STEP, corner(0, 0, 0, 0),
                               corner(65534, 65534, 65534, 65534), IDLE_STEP));
    probes.push_back(known_row(KIND_START, corner(5, 65534, 65534, 65534), corner(5, 0, 0, 0),
                               '{32'd5, 32'd0, 1'b1, 1'b0}));
    probes.push_back(known_row(KIND_STEP, corner(1, 2, 3, 4), corner(5, 6, 7, 8), IDLE_STEP));
    probes.push_back(known_row(KIND_START, corner(0, 0, 0, 0), corner(65534, 0, 0, 0),
                               '{32'd0, 32'd0, 1'b0, 1'b0}));
    probes.push_back(item_row(KIND_STEP, corner(0, 0, 0, 0), corner(0, 0, 0, 0)));
    probes.push_back(known_row(KIND_START, corner(65534, 0, 0, 0), corner(65534, 9, 9, 9),
                               '{32'd65534, 32'd0, 1'b1, 1'b0}));
    // crossed corners end the walk at once
    probes.push_back(known_row(KIND_START, corner(3, 0, 0, 0), corner(1, 0, 0, 0),
                               '{32'd3, 32'd0, 1'b1, 1'b0}));
    probes.push_back(reg_row(REG_ACTIVE_DIMS, 16'd2));
    probes.push_back(reg_row(REG_DIM_SIZE_0, 16'd3));
    probes.push_back(reg_row(REG_DIM_SIZE_1, 16'd4));
    probes.push_back(reg_row(REG_DIM_SIZE_2, 16'hFFFF));
    probes.push_back(reg_row(REG_DIM_SIZE_3, 16'd0));
    probes.push_back(item_row(KIND_START, corner(1, 1, 9, 9), corner(2, 2, 0, 0)));
    repeat (3) probes.push_back(item_row(KIND_STEP, corner(0, 0, 0, 0), corner(0, 0, 0, 0)));
    probes.push_back(known_row(KIND_STEP, corner(0, 0, 0, 0), corner(0, 0, 0, 0), IDLE_STEP));
    probes.push_back(reg_row(REG_ROW_MAJOR, 16'd0));
    probes.push_back(item_row(KIND_START, corner(1, 1, 9, 9), corner(2, 2, 0, 0)));
    repeat (3) probes.push_back(item_row(KIND_STEP, corner(0, 0, 0, 0), corner(0, 0, 0, 0)));
    // all four dims at full extent, dimension 1 crossed
    probes.push_back(reg_row(REG_ACTIVE_DIMS, 16'd4));
    probes.push_back(reg_row(REG_DIM_SIZE_0, 16'hFFFF));
    probes.push_back(reg_row(REG_DIM_SIZE_1, 16'hFFFF));
    probes.push_back(reg_row(REG_DIM_SIZE_3, 16'hFFFF));
    probes.push_back(reg_row(REG_ROW_MAJOR, 16'd1));
    probes.push_back(item_row(KIND_START, corner(0, 2, 65534, 65533), corner(1, 0, 65534, 65534)));
    repeat (3) probes.push_back(item_row(KIND_STEP, corner(0, 0, 0, 0), corner(0, 0, 0, 0)));
    // out-of-range dimension counts clamp
    probes.push_back(reg_row(REG_ACTIVE_DIMS, 16'd0));
    probes.push_back(item_row(KIND_START, corner(7, 1, 1, 1), corner(8, 0, 0, 0)));
    probes.push_back(item_row(KIND_STEP, corner(0, 0, 0, 0), corner(0, 0, 0, 0)));
    probes.push_back(reg_row(REG_ACTIVE_DIMS, 16'd7));
    probes.push_back(item_row(KIND_START, corner(0, 0, 0, 0), corner(1, 1, 0, 0)));
    probes.push_back(item_row(KIND_STEP, corner(0, 0, 0, 0), corner(0, 0, 0, 0)));
    probes.push_back(item_row(KIND_START, corner(0, 0, 0, 0), corner(1, 1, 0, 0)));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].is_reg)
        write_reg(probes[i].reg_idx, probes[i].reg_val);
      else
        push_item(probes[i].kind, probes[i].lo, probes[i].hi, probes[i].typed, probes[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          dims = 3'd4;
          row = 1'b1;
          foreach (sz[k]) sz[k] = '1;
        end
        1: begin
          dims = 3'd1;
          row = 1'b0;
          foreach (sz[k]) sz[k] = SIZE_W'(1);
        end
        2: begin
          dims = 3'd0;
          row = 1'b1;
          foreach (sz[k]) sz[k] = pick_size();
        end
        3: begin
          dims = 3'd7;
          row = 1'b0;
          foreach (sz[k]) sz[k] = pick_size();
        end
        default: begin
          dims = 3'($urandom_range(0, 7));
          row = 1'($urandom_range(0, 1));
          foreach (sz[k]) sz[k] = pick_size();
        end
      endcase
      // upper data bits are don't-care for the narrow registers
      write_reg(REG_ACTIVE_DIMS, {13'($urandom), dims});
      write_reg(REG_ROW_MAJOR, {15'($urandom), row});
      foreach (sz[k]) write_reg(CFG_IDX_W'(int'(REG_DIM_SIZE_0) + k), sz[k]);
      if (ph >= 4) begin
        write_reg(REG_SPARE_6, 16'($urandom));
        write_reg(REG_SPARE_7, 16'($urandom));
      end
      calm = (ph == 3);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          make_box(lo, hi);
          push_item(KIND_START, lo, hi, 1'b0, '0);
          while (walking) begin
            if ($urandom_range(0, 99) < 1) break;
            push_item(KIND_STEP, any_corner(), any_corner(), 1'b0, '0);
          end
          if ($urandom_range(0, 99) < 20)
            push_item(KIND_STEP, any_corner(), any_corner(), 1'b0, '0);
        end else if (r < 93) begin
          // large box, cut short by the next start
          push_item(KIND_START, any_corner(), any_corner(), 1'b0, '0);
          repeat ($urandom_range(0, 4))
            push_item(KIND_STEP, any_corner(), any_corner(), 1'b0, '0);
        end else begin
          push_item(KIND_STEP, any_corner(), any_corner(), 1'b0, '0);
        end
      end
    end
    calm = 1'b0;

    if (item_up) s_tvalid_i <= 1'b0;
    if (reg_up) cfg_valid_i <= 1'b0;
    while (pending_addr.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
